FILE: hdl/lnm_pkg.sv
// ----------------------------------------------------------------------------
// lnm_pkg
// Shared types and constants for the label-weighted nearest match block.
// ----------------------------------------------------------------------------
package lnm_pkg;

    localparam int TARGET_DEPTH = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int COORD_W      = 24;
    localparam int LABEL_W      = 8;
    localparam int PIDX_W       = 16;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int DIST_W       = 50;
    localparam int SCORE_W      = DIST_W + 1;

    localparam logic [DIST_W-1:0] MAXSQ_RESET = 50'h3_0000_0000_0001;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic [PIDX_W-1:0]         point_index;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic [LABEL_W-1:0]        class_label;
    } src_item_t;

    typedef struct packed {
        logic [PIDX_W-1:0] source_index;
        logic [IDX_W-1:0]  match_target_index;
        logic [DIST_W-1:0] match_squared_distance;
    } res_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic [LABEL_W-1:0]        class_label;
    } target_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } pipe_tag_t;

endpackage

FILE: hdl/label_weighted_nearest_match.sv
// ----------------------------------------------------------------------------
// label_weighted_nearest_match
// Brute-force nearest target search with label-weighted scoring.
// ----------------------------------------------------------------------------
// usage:
//   src channel (src_valid/src_stall/src_data) carries clear, append and
//   query items; a transfer takes place when src_valid is high and
//   src_stall is low. clear and append keep the block ready. a query
//   holds src_stall high while it walks the target memory, one target per
//   cycle through the single memory read port and the shared distance
//   pipeline, then while the pipeline drains and, with a match, while it
//   loads the result; it does not hold src_stall when the store is empty.
//   a query with a match gives one transfer on the res channel; a query
//   without one gives nothing. the result sits in an output register, so
//   the next item is taken while the result waits; a result that finds the
//   register still stalled holds the block until it drains.
//   the user must write the squared distance limit on the cfg channel only
//   while the block is idle; the block does not enforce this. cfg_ready is
//   always high.
//   reset empties the store, restores the limit to accept every distance
//   and drops any pending result.
// ----------------------------------------------------------------------------
module label_weighted_nearest_match
    import lnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  src_item_t         src_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_item_t         res_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIST_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    target_t            mem [TARGET_DEPTH];
    target_t            rd_entry_reg;

    state_t             state_reg,      state_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [CNT_W-1:0]   scan_reg,       scan_next;
    logic [DIST_W-1:0]  max_sq_reg,     max_sq_next;
    src_item_t          query_reg,      query_next;
    pipe_tag_t          rd_tag_reg,     rd_tag_next;
    logic               found_reg,      found_next;
    logic [SCORE_W-1:0] low_score_reg,  low_score_next;
    logic [DIST_W-1:0]  best_dist_reg,  best_dist_next;
    logic [IDX_W-1:0]   best_idx_reg,   best_idx_next;
    logic               res_valid_reg,  res_valid_next;
    res_item_t          res_data_reg,   res_data_next;

    logic               src_fire;
    logic               mem_we;
    target_t            wr_entry;
    target_t            query_pt;
    pipe_tag_t          dist_tag;
    logic [DIST_W-1:0]  sq_dist;
    logic [SCORE_W-1:0] score;
    logic               pipe_busy;

    assign src_stall = (state_reg != ST_IDLE);
    assign src_fire  = src_valid && !src_stall;
    assign mem_we    = src_fire && (src_data.action == ACT_APPEND)
                       && (count_reg < CNT_W'(TARGET_DEPTH));
    assign cfg_ready = 1'b1;

    assign wr_entry.x_coord     = src_data.x_coord;
    assign wr_entry.y_coord     = src_data.y_coord;
    assign wr_entry.z_coord     = src_data.z_coord;
    assign wr_entry.class_label = src_data.class_label;

    assign query_pt.x_coord     = query_reg.x_coord;
    assign query_pt.y_coord     = query_reg.y_coord;
    assign query_pt.z_coord     = query_reg.z_coord;
    assign query_pt.class_label = query_reg.class_label;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_reg[IDX_W-1:0]];
    end

    lnm_dist_pipe u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_pt),
        .entry   (rd_entry_reg),
        .tag_in  (rd_tag_reg),
        .tag_out (dist_tag),
        .sq_dist (sq_dist),
        .score   (score),
        .busy    (pipe_busy)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        max_sq_next     = max_sq_reg;
        query_next      = query_reg;
        found_next      = found_reg;
        low_score_next  = low_score_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        res_valid_next  = res_valid_reg;
        res_data_next   = res_data_reg;

        rd_tag_next.valid = (state_reg == ST_SCAN);
        rd_tag_next.idx   = scan_reg[IDX_W-1:0];

        if (cfg_valid)
        begin
            max_sq_next = cfg_data;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        // first strict improvement wins
        if (dist_tag.valid && (!found_reg || (score < low_score_reg))
            && (sq_dist < max_sq_reg))
        begin
            found_next      = 1'b1;
            low_score_next  = score;
            best_dist_next  = sq_dist;
            best_idx_next   = dist_tag.idx;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (src_fire)
                begin
                    case (src_data.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            query_next = src_data;
                            if (count_reg != '0)
                            begin
                                scan_next  = '0;
                                found_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (count_reg - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_tag_reg.valid && !pipe_busy)
                begin
                    state_next = found_reg ? ST_PUSH : ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next                       = 1'b1;
                    res_data_next.source_index           = query_reg.point_index;
                    res_data_next.match_target_index     = best_idx_reg;
                    res_data_next.match_squared_distance = best_dist_reg;
                    state_next                           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            max_sq_reg     <= MAXSQ_RESET;
            query_reg      <= '0;
            rd_tag_reg     <= '0;
            found_reg      <= 1'b0;
            low_score_reg  <= '0;
            best_dist_reg  <= '0;
            best_idx_reg   <= '0;
            res_valid_reg  <= 1'b0;
            res_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            max_sq_reg     <= max_sq_next;
            query_reg      <= query_next;
            rd_tag_reg     <= rd_tag_next;
            found_reg      <= found_next;
            low_score_reg  <= low_score_next;
            best_dist_reg  <= best_dist_next;
            best_idx_reg   <= best_idx_next;
            res_valid_reg  <= res_valid_next;
            res_data_reg   <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: hdl/lnm_dist_pipe.sv
// ----------------------------------------------------------------------------
// lnm_dist_pipe
// Three-stage squared distance and score pipeline, one target per cycle.
// ----------------------------------------------------------------------------
module lnm_dist_pipe
    import lnm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  target_t            query,
    input  target_t            entry,
    input  pipe_tag_t          tag_in,
    output pipe_tag_t          tag_out,
    output logic [DIST_W-1:0]  sq_dist,
    output logic [SCORE_W-1:0] score,
    output logic               busy
);

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            d = ~d + 1'b1;
        end
        return d[COORD_W-1:0];
    endfunction

    pipe_tag_t          tag_a_reg;
    pipe_tag_t          tag_b_reg;
    pipe_tag_t          tag_c_reg;
    logic [COORD_W-1:0] ad_x_reg;
    logic [COORD_W-1:0] ad_y_reg;
    logic [COORD_W-1:0] ad_z_reg;
    logic               lab_a_reg;
    logic [SQ_W-1:0]    sq_x_reg;
    logic [SQ_W-1:0]    sq_y_reg;
    logic [SQ_W-1:0]    sq_z_reg;
    logic               lab_b_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [DIST_W-1:0]  dist_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    assign dist_next = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);

    always_ff @(posedge clk)
    begin
        ad_x_reg  <= abs_diff(query.x_coord, entry.x_coord);
        ad_y_reg  <= abs_diff(query.y_coord, entry.y_coord);
        ad_z_reg  <= abs_diff(query.z_coord, entry.z_coord);
        lab_a_reg <= (query.class_label != '0) || (entry.class_label != '0);
        sq_x_reg  <= ad_x_reg * ad_x_reg;
        sq_y_reg  <= ad_y_reg * ad_y_reg;
        sq_z_reg  <= ad_z_reg * ad_z_reg;
        lab_b_reg <= lab_a_reg;
        dist_reg  <= dist_next;
        // labeled pairs count half, so unlabeled ones are doubled instead
        score_reg <= lab_b_reg ? {1'b0, dist_next} : {dist_next, 1'b0};
    end

    assign tag_out = tag_c_reg;
    assign sq_dist = dist_reg;
    assign score   = score_reg;
    assign busy    = tag_a_reg.valid || tag_b_reg.valid || tag_c_reg.valid;

endmodule

FILE: hdl/lnm_checker.sv
// ----------------------------------------------------------------------------
// lnm_checker
// Port-level checks for the label-weighted nearest match block.
// ----------------------------------------------------------------------------
module lnm_checker
    import lnm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              src_valid,
    input logic              src_stall,
    input src_item_t         src_data,
    input logic              res_valid,
    input logic              res_stall,
    input res_item_t         res_data
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
    else $error("result payload changed while stalled");

    // clear and append leave src_stall low in the cycle after they are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall
        && ((src_data.action == ACT_CLEAR) || (src_data.action == ACT_APPEND))
        |=> !src_stall)
    else $error("store update did not complete in one cycle");

    // a new result only appears at the end of a search
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_stall))
    else $error("result appeared without a search");

endmodule

bind label_weighted_nearest_match lnm_checker u_checker (.*);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for label_weighted_nearest_match. A short directed run
// covers corner points, ties, label weighting and the empty store, then
// random clear/append/query bursts run under several distance limits. A
// scoreboard predicts each match and checks every result transfer in order,
// while the source idles and the result side stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import lnm_pkg::*;

    localparam logic [1:0] ACT_UNUSED       = 2'd3;
    localparam int         CMIN             = -8388608;
    localparam int         CMAX             = 8388607;
    localparam int         STYLE_WIDE       = 0;
    localparam int         STYLE_NEAR       = 1;
    localparam int         STYLE_RAIL       = 2;
    localparam int         STYLE_MIXED      = 3;
    localparam int         RANDOM_PER_PHASE = 104;
    localparam int         DRAIN_CYCLES     = TARGET_DEPTH + 16;
    localparam int         HOLD_CYCLES      = 1500;
    localparam int         CYCLE_LIMIT      = 2000000;

    class match_predictor;
        target_t           targets[TARGET_DEPTH];
        int unsigned       fill;
        logic [DIST_W-1:0] limit;
        res_item_t         pending_matches[$];
        int                errors;

        function new();
            fill   = 0;
            limit  = MAXSQ_RESET;
            errors = 0;
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction

        function logic [DIST_W-1:0] squared_gap(target_t t, src_item_t it);
            longint dx, dy, dz;
            dx = longint'($signed(t.x_coord)) - longint'($signed(it.x_coord));
            dy = longint'($signed(t.y_coord)) - longint'($signed(it.y_coord));
            dz = longint'($signed(t.z_coord)) - longint'($signed(it.z_coord));
            return DIST_W'(dx * dx + dy * dy + dz * dz);
        endfunction

        function void take_item(src_item_t it);
            logic                found;
            logic [SCORE_W-1:0]  low_score;
            logic [SCORE_W-1:0]  score;
            logic [DIST_W-1:0]   best_dist;
            logic [DIST_W-1:0]   d;
            int                  best_idx;
            res_item_t           m;
            case (it.action)
                ACT_CLEAR:
                begin
                    fill = 0;
                end
                ACT_APPEND:
                begin
                    if (fill < TARGET_DEPTH)
                    begin
                        targets[fill] = {it.x_coord, it.y_coord, it.z_coord, it.class_label};
                        fill++;
                    end
                end
                ACT_QUERY:
                begin
                    found      = 1'b0;
                    low_score  = '0;
                    best_dist  = '0;
                    best_idx   = 0;
                    for (int j = 0; j < fill; j++)
                    begin
                        d = squared_gap(targets[j], it);
                        // a label on either side halves the score
                        if (it.class_label != 0 || targets[j].class_label != 0)
                            score = {1'b0, d};
                        else
                            score = {d, 1'b0};
                        if ((!found || score < low_score) && d < limit)
                        begin
                            found      = 1'b1;
                            low_score  = score;
                            best_dist  = d;
                            best_idx   = j;
                        end
                    end
                    if (found)
                    begin
                        m.source_index           = it.point_index;
                        m.match_target_index     = best_idx[IDX_W-1:0];
                        m.match_squared_distance = best_dist;
                        pending_matches.insert(pending_matches.size(), m);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_match(res_item_t got);
            res_item_t want;
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result transfer, source_index %0d", got.source_index);
                errors++;
                return;
            end
            want = pending_matches.pop_front();
            if (got.source_index !== want.source_index)
            begin
                $error("source_index expected %0d actual %0d",
                       want.source_index, got.source_index);
                errors++;
            end
            if (got.match_target_index !== want.match_target_index)
            begin
                $error("match_target_index expected %0d actual %0d",
                       want.match_target_index, got.match_target_index);
                errors++;
            end
            if (got.match_squared_distance !== want.match_squared_distance)
            begin
                $error("match_squared_distance expected %0d actual %0d",
                       want.match_squared_distance, got.match_squared_distance);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              src_valid = 1'b0;
    logic              src_stall;
    src_item_t         src_data  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_item_t         res_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [DIST_W-1:0] cfg_data  = '0;

    match_predictor board = new();
    bit             gaps_on      = 1'b1;
    int             sent_items   = 0;
    int             results_seen = 0;

    label_weighted_nearest_match u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int rand_coord(int style);
        int s;
        s = (style == STYLE_MIXED) ? $urandom_range(0, 2) : style;
        case (s)
            STYLE_NEAR: return int'($urandom_range(0, 64)) - 32;
            STYLE_RAIL: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
            default:    return int'($urandom_range(0, 32'hFFFFFF)) + CMIN;
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] rand_limit(int shift);
        logic [DIST_W-1:0] v;
        v = DIST_W'({$urandom, $urandom});
        v = v >> shift;
        if (v > MAXSQ_RESET)
            v = v - MAXSQ_RESET;
        return v;
    endfunction

    function automatic src_item_t mk(logic [1:0] act, logic [PIDX_W-1:0] pidx,
                                     int x, int y, int z, logic [LABEL_W-1:0] lab);
        src_item_t it;
        it.action      = act;
        it.point_index = pidx;
        it.x_coord     = x[COORD_W-1:0];
        it.y_coord     = y[COORD_W-1:0];
        it.z_coord     = z[COORD_W-1:0];
        it.class_label = lab;
        return it;
    endfunction

    function automatic src_item_t random_item(logic [1:0] act, int style);
        logic [LABEL_W-1:0] lab;
        lab = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 255));
        return mk(act, 16'($urandom), rand_coord(style), rand_coord(style),
                  rand_coord(style), lab);
    endfunction

    task automatic send_item(input src_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        do @(posedge clk); while (src_stall);
        board.take_item(it);
        if (it.action != ACT_UNUSED)
            sent_items++;
    endtask

    // a query without a match may still be walking the store
    task automatic settle();
        src_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [DIST_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.limit = value;
    endtask

    task automatic run_burst(input bit near);
        int style;
        int n_app;
        int n_qry;
        gaps_on = ($urandom_range(0, 3) != 0);
        if (near && $urandom_range(0, 4) != 0)
            style = STYLE_NEAR;
        else
            style = $urandom_range(STYLE_WIDE, STYLE_MIXED);
        if ($urandom_range(0, 9) == 0)
            send_item(random_item(2'($urandom), style));
        if ($urandom_range(0, 3) != 0)
            send_item(random_item(ACT_CLEAR, style));
        n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        repeat (n_app) send_item(random_item(ACT_APPEND, style));
        n_qry = $urandom_range(1, 6);
        repeat (n_qry) send_item(random_item(ACT_QUERY, style));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            board.check_match(res_data);
            results_seen++;
        end
    end

    // result side: random stalls, plus one long hold so the block backs up
    initial
    begin : receiver
        int  n;
        int  r;
        bit  held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 15)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            r = $urandom_range(0, 9);
            n = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int                goal;
        logic [DIST_W-1:0] lim;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store and unused action
        send_item(mk(ACT_QUERY,  16'hFFFF, 0, 0, 0, 8'd0));
        send_item(mk(ACT_UNUSED, 16'h1234, 1, 2, 3, 8'd7));
        // corner points and an exact tie
        send_item(mk(ACT_APPEND, 16'hFFFF, CMIN, CMIN, CMIN, 8'd0));
        send_item(mk(ACT_APPEND, 16'h0000, CMAX, CMAX, CMAX, 8'd255));
        send_item(mk(ACT_APPEND, 16'h0000, 0, 0, 0, 8'd0));
        send_item(mk(ACT_APPEND, 16'h5555, 0, 0, 0, 8'd0));
        send_item(mk(ACT_QUERY,  16'hFFFF, CMAX, CMAX, CMAX, 8'd0));
        send_item(mk(ACT_QUERY,  16'h0000, CMIN, CMIN, CMIN, 8'd0));
        send_item(mk(ACT_QUERY,  16'h0001, 0, 0, 0, 8'd0));
        send_item(mk(ACT_QUERY,  16'h0002, CMIN, CMAX, CMIN, 8'd128));
        // clear keeps old entries out of reach
        send_item(mk(ACT_CLEAR,  16'hABCD, CMAX, CMIN, CMAX, 8'd255));
        send_item(mk(ACT_QUERY,  16'h0003, 0, 0, 0, 8'd0));
        // largest possible distance
        send_item(mk(ACT_APPEND, 16'h0000, CMIN, CMIN, CMIN, 8'd0));
        send_item(mk(ACT_QUERY,  16'h8000, CMAX, CMAX, CMAX, 8'd0));
        // label weighting lets a farther labeled target win
        send_item(mk(ACT_APPEND, 16'h0000, 1, 1, 1, 8'd0));
        send_item(mk(ACT_APPEND, 16'h0000, 2, 1, 0, 8'd9));
        send_item(mk(ACT_QUERY,  16'h0004, 0, 0, 0, 8'd0));
        send_item(mk(ACT_QUERY,  16'h0005, 0, 0, 0, 8'd1));
        send_item(mk(ACT_APPEND, 16'h0000, -1, -1, -1, 8'd0));
        send_item(mk(ACT_QUERY,  16'h0006, 0, 0, 0, 8'd200));
        send_item(mk(ACT_QUERY,  16'h0007, 0, 0, 0, 8'd0));

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       lim = rand_limit(0);
                1:       lim = DIST_W'($urandom_range(1, 20000));
                2:       lim = '0;
                3:       lim = rand_limit($urandom_range(1, 49));
                default: lim = MAXSQ_RESET;
            endcase
            write_limit(lim);
            goal = sent_items + RANDOM_PER_PHASE;
            while (sent_items < goal)
                run_burst(phase == 1);
        end

        settle();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hdl/lnm_pkg.sv
hdl/lnm_dist_pipe.sv
hdl/label_weighted_nearest_match.sv
hdl/lnm_checker.sv
test/tb.sv
